// File: hw/rtl/i2c_command_nibble_packer_top_assert.svh
// Assertion macros used by the command nibble packer top module.
`ifndef I2C_COMMAND_NIBBLE_PACKER_TOP_ASSERT_SVH
`define I2C_COMMAND_NIBBLE_PACKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CNP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2cnp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CNP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2cnp assertion failed");

`endif

// File: hw/rtl/i2cnp_pkg.sv
`default_nettype none
package i2cnp_pkg;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_SLEEP = 3'd4,
        OP_END   = 3'd5,
        OP_RESET = 3'd6,
        OP_NONE  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        CSRC_CONST,
        CSRC_DATA,
        CSRC_RDLAST
    } t_csrc;

    localparam logic [3:0] CODE_PAD     = 4'h0;
    localparam logic [3:0] CODE_SCL_LO  = 4'h2;
    localparam logic [3:0] CODE_SCL_HI  = 4'h3;
    localparam logic [3:0] CODE_SDA_LO  = 4'h4;
    localparam logic [3:0] CODE_SDA_HI  = 4'h5;
    localparam logic [3:0] CODE_RESET   = 4'h6;
    localparam logic [3:0] CODE_SLEEP   = 4'h7;
    localparam logic [3:0] CODE_BIT0    = 4'h8;
    localparam logic [3:0] CODE_BIT1    = 4'hC;
    localparam logic [3:0] CODE_RD_ACK  = 4'h8;
    localparam logic [3:0] CODE_RD_NACK = 4'hC;
    localparam logic [3:0] CODE_READ    = 4'hD;
    localparam logic [3:0] CODE_ACK     = 4'hE;

    localparam logic [6:0] MAX_SLEEP = 7'd64;
    localparam logic [6:0] BYTE_BITS = 7'd8;

    typedef logic [3:0] t_step;

    localparam t_step ENT_START = 4'd0;
    localparam t_step ENT_STOP  = 4'd4;
    localparam t_step ENT_WRITE = 4'd7;
    localparam t_step ENT_READ  = 4'd9;
    localparam t_step ENT_SLEEP = 4'd11;
    localparam t_step ENT_END   = 4'd12;
    localparam t_step ENT_RESET = 4'd14;

    typedef struct packed {
        logic [3:0] code;
        t_csrc      src;
        logic       loop;
        logic       fin;
        logic       fin_if_pend;
    } t_uop;

    typedef struct packed {
        logic        valid;
        logic [3:0]  code;
        logic        last;
        logic [15:0] ridx;
    } t_push;

    typedef struct packed {
        logic ready;
        logic pend_valid;
    } t_pk_stat;

    function automatic t_uop uop_rom(t_step a);
        t_uop u;
        unique case (a)
            4'd0:    u = '{CODE_SDA_HI, CSRC_CONST,  1'b0, 1'b0, 1'b0};
            4'd1:    u = '{CODE_SCL_HI, CSRC_CONST,  1'b0, 1'b0, 1'b0};
            4'd2:    u = '{CODE_SDA_LO, CSRC_CONST,  1'b0, 1'b0, 1'b0};
            4'd3:    u = '{CODE_SCL_LO, CSRC_CONST,  1'b0, 1'b1, 1'b0};
            4'd4:    u = '{CODE_SDA_LO, CSRC_CONST,  1'b0, 1'b0, 1'b0};
            4'd5:    u = '{CODE_SCL_HI, CSRC_CONST,  1'b0, 1'b0, 1'b0};
            4'd6:    u = '{CODE_SDA_HI, CSRC_CONST,  1'b0, 1'b1, 1'b0};
            4'd7:    u = '{CODE_BIT0,   CSRC_DATA,   1'b1, 1'b0, 1'b0};
            4'd8:    u = '{CODE_ACK,    CSRC_CONST,  1'b0, 1'b1, 1'b0};
            4'd9:    u = '{CODE_READ,   CSRC_CONST,  1'b1, 1'b0, 1'b0};
            4'd10:   u = '{CODE_RD_ACK, CSRC_RDLAST, 1'b0, 1'b1, 1'b0};
            4'd11:   u = '{CODE_SLEEP,  CSRC_CONST,  1'b1, 1'b1, 1'b0};
            4'd12:   u = '{CODE_PAD,    CSRC_CONST,  1'b0, 1'b0, 1'b1};
            4'd13:   u = '{CODE_PAD,    CSRC_CONST,  1'b0, 1'b1, 1'b0};
            4'd14:   u = '{CODE_RESET,  CSRC_CONST,  1'b0, 1'b1, 1'b0};
            default: u = '{CODE_PAD,    CSRC_CONST,  1'b0, 1'b1, 1'b0};
        endcase
        return u;
    endfunction

    function automatic t_step op_entry(t_op op);
        t_step s;
        unique case (op)
            OP_START: s = ENT_START;
            OP_STOP:  s = ENT_STOP;
            OP_WRITE: s = ENT_WRITE;
            OP_READ:  s = ENT_READ;
            OP_SLEEP: s = ENT_SLEEP;
            OP_END:   s = ENT_END;
            OP_RESET: s = ENT_RESET;
            default:  s = ENT_RESET;
        endcase
        return s;
    endfunction

    // Number of command codes that one operation emits.
    function automatic logic [6:0] op_codes(t_op op, logic pend, logic [6:0] sleep_n);
        logic [6:0] n;
        unique case (op)
            OP_START: n = 7'd4;
            OP_STOP:  n = 7'd3;
            OP_WRITE: n = 7'd9;
            OP_READ:  n = 7'd9;
            OP_SLEEP: n = sleep_n;
            OP_END:   n = pend ? 7'd1 : 7'd2;
            OP_RESET: n = 7'd1;
            default:  n = 7'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/i2cnp_packer.sv
`default_nettype none
module i2cnp_packer #(
    parameter int CMD_BYTES = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire i2cnp_pkg::t_push   i_push,
    output i2cnp_pkg::t_pk_stat     o_stat,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_cmd_byte,
    output logic [11:0]             o_byte_position,
    output logic                    o_wrapped,
    output logic [15:0]             o_read_index,
    output logic                    o_last
);
    import i2cnp_pkg::*;

    localparam int POS_W = $clog2(CMD_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CMD_BYTES - 1);

    logic             r_pend_valid;
    logic [3:0]       r_pend_code;
    logic [POS_W-1:0] r_wpos;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [11:0]      r_out_pos;
    logic             r_out_wrap;
    logic [15:0]      r_out_ridx;
    logic             r_out_last;

    logic w_ready;
    logic w_take;
    logic w_emit;
    logic w_wrap;

    assign w_ready = !r_pend_valid || !r_out_valid || i_out_ready;
    assign w_take  = i_push.valid && w_ready;
    assign w_emit  = w_take && r_pend_valid;
    assign w_wrap  = (r_wpos == POS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_code  <= '0;
            r_wpos       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_pend_valid <= !r_pend_valid;
                r_pend_code  <= r_pend_valid ? 4'h0 : i_push.code;
            end
            if (w_emit) begin
                r_wpos      <= w_wrap ? '0 : r_wpos + POS_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= {i_push.code, r_pend_code};
            r_out_pos  <= 12'(r_wpos);
            r_out_wrap <= w_wrap;
            r_out_ridx <= i_push.ridx;
            r_out_last <= i_push.last;
        end
    end

    assign o_stat.ready      = w_ready;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_out_valid       = r_out_valid;
    assign o_cmd_byte        = r_out_byte;
    assign o_byte_position   = r_out_pos;
    assign o_wrapped         = r_out_wrap;
    assign o_read_index      = r_out_ridx;
    assign o_last            = r_out_last;

endmodule
`default_nettype wire

// File: hw/rtl/i2c_command_nibble_packer_top.sv
`default_nettype none
// Turns I2C bus operations into 4-bit command codes packed two to a byte, first code in the
// low nibble. One operation is accepted at a time; a microcode sequencer then emits one
// command code per clock while the output is taken promptly. Codes per operation: start 4,
// stop 3, write or read byte 9, sleep of n ticks n (ticks saturate at 64), end 1 or 2,
// reset 1. Operation code 7 and a sleep of zero ticks are taken and give no word. Each
// completed byte is a word with its store position, a wrap flag, the read index for read
// bytes, and a last flag on the final word of the operation; a stalled output word holds
// the sequencer at its next completing code.
module i2c_command_nibble_packer_top #(
    parameter int CMD_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_read,
    input  wire logic [6:0]  i_sleep_ticks,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_cmd_byte,
    output logic [11:0]      o_byte_position,
    output logic             o_wrapped,
    output logic [15:0]      o_read_index,
    output logic             o_last
);
    import i2cnp_pkg::*;
    `include "i2c_command_nibble_packer_top_assert.svh"

    logic        r_busy, n_busy;
    t_step       r_step, n_step;
    logic [6:0]  r_cnt, n_cnt;
    logic [6:0]  r_left, n_left;
    logic [7:0]  r_data, n_data;
    logic        r_last_read, n_last_read;
    logic [15:0] r_ridx, n_ridx;
    logic [15:0] r_rdcnt, n_rdcnt;

    t_op        w_op;
    logic [6:0] w_sleep_n;
    logic       w_acc;
    logic       w_go;
    logic       w_done;
    t_uop       w_uop;
    t_push      w_push;
    t_pk_stat   w_stat;

    assign w_op      = t_op'(i_operation);
    assign w_sleep_n = (i_sleep_ticks > MAX_SLEEP) ? MAX_SLEEP : i_sleep_ticks;
    assign o_in_ready = !r_busy;
    assign w_acc     = i_in_valid && !r_busy;
    assign w_uop     = uop_rom(r_step);
    assign w_go      = r_busy && w_stat.ready;
    assign w_done    = !(w_uop.loop && (r_cnt != 7'd1))
                       && (w_uop.fin || (w_uop.fin_if_pend && w_stat.pend_valid));

    always_comb begin
        w_push.valid = r_busy;
        w_push.last  = (r_left <= 7'd2);
        w_push.ridx  = r_ridx;
        case (w_uop.src)
            CSRC_DATA:   w_push.code = r_data[7] ? CODE_BIT1 : CODE_BIT0;
            CSRC_RDLAST: w_push.code = r_last_read ? CODE_RD_NACK : CODE_RD_ACK;
            default:     w_push.code = w_uop.code;
        endcase
    end

    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_data      = r_data;
        n_last_read = r_last_read;
        n_ridx      = r_ridx;
        n_rdcnt     = r_rdcnt;
        if (w_acc) begin
            n_busy      = (w_op != OP_NONE) && !((w_op == OP_SLEEP) && (w_sleep_n == 7'd0));
            n_step      = op_entry(w_op);
            n_cnt       = (w_op == OP_SLEEP) ? w_sleep_n : BYTE_BITS;
            n_left      = op_codes(w_op, w_stat.pend_valid, w_sleep_n);
            n_data      = i_data_byte;
            n_last_read = i_last_read;
            n_ridx      = (w_op == OP_READ) ? r_rdcnt : 16'd0;
            if (w_op == OP_READ) begin
                n_rdcnt = r_rdcnt + 16'd1;
            end
        end else if (w_go) begin
            n_left = r_left - 7'd1;
            if (w_uop.src == CSRC_DATA) begin
                n_data = {r_data[6:0], 1'b0};
            end
            if (w_uop.loop && (r_cnt != 7'd1)) begin
                n_cnt = r_cnt - 7'd1;
            end else if (w_done) begin
                n_busy = 1'b0;
            end else begin
                n_step = r_step + t_step'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
            r_rdcnt <= '0;
        end else begin
            r_busy  <= n_busy;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_rdcnt <= n_rdcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data      <= n_data;
        r_last_read <= n_last_read;
        r_ridx      <= n_ridx;
    end

    i2cnp_packer #(
        .CMD_BYTES(CMD_BYTES)
    ) u_packer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_push),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cmd_byte      (o_cmd_byte),
        .o_byte_position (o_byte_position),
        .o_wrapped       (o_wrapped),
        .o_read_index    (o_read_index),
        .o_last          (o_last)
    );

    `I2CNP_ASSERT_IMP(a_busy_has_codes, r_busy, r_left != 7'd0)
    `I2CNP_ASSERT_NXT(a_final_step_idles, (w_go && w_done), !r_busy)
    `I2CNP_ASSERT_NXT(a_read_counts, (w_acc && (w_op == OP_READ)), r_rdcnt == $past(r_rdcnt) + 16'd1)
    `I2CNP_ASSERT_IMP(a_final_step_last, (w_go && w_done && w_stat.pend_valid), w_push.last)

endmodule
`default_nettype wire
